@@ rtl/core/aabb_ct_pkg.sv @@
// Package for the AABB contact tracker: payload structs, event codes,
// configuration register indexes and fixed field widths. No dependencies.
package aabb_ct_pkg;

    localparam int ID_W      = 6;
    localparam int LAYER_W   = 4;
    localparam int COORD_W   = 24;
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MASK_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MASK_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MASK_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_MASK_3 = 8'd3;

    typedef struct packed {
        logic        [ID_W-1:0]    left_id;
        logic        [ID_W-1:0]    right_id;
        logic        [LAYER_W-1:0] left_layer;
        logic        [LAYER_W-1:0] right_layer;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] left_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic signed [COORD_W-1:0] left_w;
        logic signed [COORD_W-1:0] left_h;
        logic signed [COORD_W-1:0] right_w;
        logic signed [COORD_W-1:0] right_h;
    } t_item;

    typedef struct packed {
        t_event event_res;
        logic   overlap;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [MASK_W-1:0]    wdata;
    } t_cfg;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctl;

endpackage

@@ rtl/core/aabb_ct_ifs.sv @@
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on aabb_ct_pkg for the payload types.
interface aabb_ct_item_if;
    logic                valid;
    logic                ready;
    aabb_ct_pkg::t_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aabb_ct_res_if;
    logic                 valid;
    logic                 ready;
    aabb_ct_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aabb_ct_cfg_if;
    logic              valid;
    logic              ready;
    aabb_ct_pkg::t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/aabb_ct_store.sv @@
// Contact store: one row of contact bits per left id, one read and one write port,
// a write-to-read bypass and a clearing pass after reset. Depends on aabb_ct_pkg.
module aabb_ct_store #(
    parameter int ID_BITS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aabb_ct_pkg::t_store_ctl    i_ctl,
    input  logic [ID_BITS-1:0]         i_rd_addr,
    input  logic [ID_BITS-1:0]         i_wr_addr,
    input  logic [(2**ID_BITS)-1:0]    i_wr_row,
    output logic [(2**ID_BITS)-1:0]    o_rd_row,
    output logic                       o_busy
);
    localparam int ROWS = 2**ID_BITS;

    logic [ROWS-1:0]    r_mem [ROWS];
    logic [ROWS-1:0]    r_q;
    logic [ROWS-1:0]    r_byp_row;
    logic               r_byp;
    logic               r_clr_busy;
    logic [ID_BITS-1:0] r_clr_row;
    logic               w_we;
    logic [ID_BITS-1:0] w_wa;
    logic [ROWS-1:0]    w_wd;

    always_comb begin
        w_we = r_clr_busy || i_ctl.wr_en;
        w_wa = r_clr_busy ? r_clr_row : i_wr_addr;
        w_wd = r_clr_busy ? '0 : i_wr_row;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_q       <= r_mem[i_rd_addr];
            r_byp_row <= i_wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp      <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else begin
            if (i_ctl.rd_en) begin
                r_byp <= i_ctl.wr_en && (i_wr_addr == i_rd_addr);
            end
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == {ID_BITS{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rd_row = r_byp ? r_byp_row : r_q;
    assign o_busy   = r_clr_busy;

    a_no_read_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rd_en |-> !r_clr_busy)
        else $error("contact store read during clearing pass");

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en |-> !r_clr_busy)
        else $error("contact store write during clearing pass");

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_row) == {ID_BITS{1'b1}})
        else $error("clearing pass ended before the last row");

endmodule

@@ rtl/core/aabb_contact_tracker_top.sv @@
// AABB contact tracker top level: layer mask registers, overlap test, contact
// update and result register. Depends on aabb_ct_pkg, aabb_ct_ifs, aabb_ct_store.
// An item passes the stage-one register and the result register, and a new item
// can be accepted every cycle while results are taken; the contact row memory,
// read in the accept cycle and written as the item leaves stage one, with a bypass
// for back-to-back items on the same row, sets that rate. After reset the block
// clears the store one row per cycle, 2**ID_BITS rows (64 by default), and accepts
// no item until that pass is over; configuration writes are taken at any time.
module aabb_contact_tracker_top #(
    parameter int LAYERS  = 16,
    parameter int ID_BITS = 6
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    aabb_ct_item_if.sink        i_item,
    aabb_ct_res_if.source       o_res,
    aabb_ct_cfg_if.sink         i_cfg
);
    localparam int CW   = aabb_ct_pkg::COORD_W;
    localparam int LW   = aabb_ct_pkg::LAYER_W;
    localparam int ROWS = 2**ID_BITS;
    localparam logic [LW:0] LAYER_LIM = (LW + 1)'(LAYERS);

    function automatic logic [CW:0] mag(input logic [CW:0] v);
        return v[CW] ? (~v + 1'b1) : v;
    endfunction

    logic [aabb_ct_pkg::MASK_W-1:0] r_mask [4];

    logic               r_s1_vld;
    logic               r_s1_en;
    logic [ID_BITS-1:0] r_s1_lid;
    logic [ID_BITS-1:0] r_s1_rid;
    logic [CW:0]        r_s1_dx;
    logic [CW:0]        r_s1_dy;
    logic [CW:0]        r_s1_sx;
    logic [CW:0]        r_s1_sy;

    logic                 r_out_vld;
    aabb_ct_pkg::t_result r_out;
    aabb_ct_pkg::t_result n_out;

    logic                    w_acc;
    logic                    w_s1_adv;
    logic                    w_busy;
    logic [ID_BITS-1:0]      w_lid;
    logic [ID_BITS-1:0]      w_rid;
    logic                    w_layer_ok;
    logic                    w_en;
    logic [CW:0]             w_dx;
    logic [CW:0]             w_dy;
    logic [CW:0]             w_sx;
    logic [CW:0]             w_sy;
    logic [ROWS-1:0]         w_rd_row;
    logic [ROWS-1:0]         w_new_row;
    logic                    w_had;
    logic                    w_hit;
    aabb_ct_pkg::t_store_ctl w_ctl;

    always_comb begin
        w_lid      = ID_BITS'(i_item.data.left_id);
        w_rid      = ID_BITS'(i_item.data.right_id);
        w_layer_ok = ({1'b0, i_item.data.left_layer} < LAYER_LIM)
                  && ({1'b0, i_item.data.right_layer} < LAYER_LIM);
        w_en       = w_layer_ok && (w_lid != w_rid)
                  && r_mask[i_item.data.left_layer[LW-1:LW-2]]
                           [{i_item.data.left_layer[1:0], i_item.data.right_layer}];
        w_dx = mag({i_item.data.left_x[CW-1], i_item.data.left_x}
                 - {i_item.data.right_x[CW-1], i_item.data.right_x});
        w_dy = mag({i_item.data.left_y[CW-1], i_item.data.left_y}
                 - {i_item.data.right_y[CW-1], i_item.data.right_y});
        w_sx = mag({i_item.data.left_w[CW-1], i_item.data.left_w}
                 + {i_item.data.right_w[CW-1], i_item.data.right_w});
        w_sy = mag({i_item.data.left_h[CW-1], i_item.data.left_h}
                 + {i_item.data.right_h[CW-1], i_item.data.right_h});
    end

    assign w_s1_adv       = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_item.ready   = !w_busy && (!r_s1_vld || w_s1_adv);
    assign w_acc          = i_item.valid && i_item.ready;
    assign i_cfg.ready    = 1'b1;
    assign o_res.valid    = r_out_vld;
    assign o_res.data     = r_out;

    always_comb begin
        w_had     = w_rd_row[r_s1_rid];
        w_hit     = ({r_s1_dx, 1'b0} < {1'b0, r_s1_sx})
                 && ({r_s1_dy, 1'b0} < {1'b0, r_s1_sy});
        w_new_row = w_rd_row;
        w_new_row[r_s1_rid] = w_hit;
        n_out.overlap   = r_s1_en && w_hit;
        n_out.event_res = aabb_ct_pkg::EV_NONE;
        if (r_s1_en) begin
            if (w_hit && w_had) begin
                n_out.event_res = aabb_ct_pkg::EV_STAY;
            end else if (w_hit) begin
                n_out.event_res = aabb_ct_pkg::EV_ENTER;
            end else if (w_had) begin
                n_out.event_res = aabb_ct_pkg::EV_EXIT;
            end
        end
        w_ctl.rd_en = w_acc;
        w_ctl.wr_en = w_s1_adv && r_s1_en;
    end

    aabb_ct_store #(
        .ID_BITS (ID_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_lid),
        .i_wr_addr (r_s1_lid),
        .i_wr_row  (w_new_row),
        .o_rd_row  (w_rd_row),
        .o_busy    (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[0] <= '0;
            r_mask[1] <= '0;
            r_mask[2] <= '0;
            r_mask[3] <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.idx)
                aabb_ct_pkg::CFG_LAYER_MASK_0: r_mask[0] <= i_cfg.data.wdata;
                aabb_ct_pkg::CFG_LAYER_MASK_1: r_mask[1] <= i_cfg.data.wdata;
                aabb_ct_pkg::CFG_LAYER_MASK_2: r_mask[2] <= i_cfg.data.wdata;
                aabb_ct_pkg::CFG_LAYER_MASK_3: r_mask[3] <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_en  <= w_en;
            r_s1_lid <= w_lid;
            r_s1_rid <= w_rid;
            r_s1_dx  <= w_dx;
            r_s1_dy  <= w_dy;
            r_s1_sx  <= w_sx;
            r_s1_sy  <= w_sy;
        end
        if (w_s1_adv) begin
            r_out <= n_out;
        end
    end

    a_enter_overlaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.event_res == aabb_ct_pkg::EV_ENTER) |-> r_out.overlap)
        else $error("enter event without overlap");

    a_exit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.event_res == aabb_ct_pkg::EV_EXIT) |-> !r_out.overlap)
        else $error("exit event while overlapping");

    a_none_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.event_res == aabb_ct_pkg::EV_NONE) |-> !r_out.overlap)
        else $error("overlap reported without an event");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_vld)
        else $error("completed item did not reach the result register");

endmodule

@@ test/aabb_ct_contact_check.sv @@
`timescale 1ns / 100ps
// Contact checker for the AABB contact tracker: watches the item, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on aabb_ct_pkg and the channel interfaces in aabb_ct_ifs.
module aabb_ct_contact_check
    import aabb_ct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    aabb_ct_item_if  i_item,
    aabb_ct_res_if   i_res,
    aabb_ct_cfg_if   i_cfg,
    output int       o_errors,
    output int       o_pending,
    output int       o_enters,
    output int       o_stays,
    output int       o_exits
);

    logic [MASK_W-1:0] layer_masks [4];
    bit                contact_bits [0:(1 << (2 * ID_W)) - 1];
    t_result           expected_results [$];

    function automatic bit axis_overlap(
        input logic signed [COORD_W-1:0] ca,
        input logic signed [COORD_W-1:0] cb,
        input logic signed [COORD_W-1:0] sa,
        input logic signed [COORD_W-1:0] sb
    );
        longint gap;
        longint span;
        gap = longint'(ca) - longint'(cb);
        if (gap < 0) gap = -gap;
        span = longint'(sa) + longint'(sb);
        if (span < 0) span = -span;
        return (2 * gap) < span;
    endfunction

    function automatic t_result predict_contact(input t_item it);
        t_result             res;
        logic [MASK_W-1:0]   row_word;
        logic [2*ID_W-1:0]   slot;
        bit                  enabled;
        bit                  hit;
        bit                  had;
        res.event_res = EV_NONE;
        res.overlap   = 1'b0;
        row_word = layer_masks[it.left_layer[3:2]];
        enabled  = row_word[{it.left_layer[1:0], it.right_layer}];
        if (enabled && it.left_id != it.right_id) begin
            slot = {it.left_id, it.right_id};
            had  = contact_bits[slot];
            hit  = axis_overlap(it.left_x, it.right_x, it.left_w, it.right_w) &&
                   axis_overlap(it.left_y, it.right_y, it.left_h, it.right_h);
            if (hit) begin
                res.overlap = 1'b1;
                if (had) begin
                    res.event_res = EV_STAY;
                end else begin
                    res.event_res = EV_ENTER;
                    contact_bits[slot] = 1'b1;
                end
            end else if (had) begin
                res.event_res = EV_EXIT;
                contact_bits[slot] = 1'b0;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (layer_masks[k]) layer_masks[k] = '0;
            foreach (contact_bits[k]) contact_bits[k] = 1'b0;
            expected_results.delete();
            o_errors = 0;
            o_enters = 0;
            o_stays  = 0;
            o_exits  = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.idx)
                    CFG_LAYER_MASK_0: layer_masks[0] = i_cfg.data.wdata;
                    CFG_LAYER_MASK_1: layer_masks[1] = i_cfg.data.wdata;
                    CFG_LAYER_MASK_2: layer_masks[2] = i_cfg.data.wdata;
                    CFG_LAYER_MASK_3: layer_masks[3] = i_cfg.data.wdata;
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                case (got.event_res)
                    EV_ENTER: o_enters++;
                    EV_STAY:  o_stays++;
                    EV_EXIT:  o_exits++;
                    default: ;
                endcase
                if (expected_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with none expected: expected nothing, got %s/%0b",
                             $time, got.event_res.name(), got.overlap);
                end else begin
                    want = expected_results.pop_front();
                    if (got.event_res !== want.event_res) begin
                        o_errors++;
                        $display("%0t: event_res mismatch: expected %s, got %s",
                                 $time, want.event_res.name(), got.event_res.name());
                    end
                    if (got.overlap !== want.overlap) begin
                        o_errors++;
                        $display("%0t: overlap mismatch: expected %0b, got %0b",
                                 $time, want.overlap, got.overlap);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_results.push_back(predict_contact(i_item.data));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ test/aabb_contact_tracker_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the AABB contact tracker: clock, reset, item stimulus,
// result back-pressure, layer mask writes and the verdict.
// Depends on aabb_ct_pkg, aabb_ct_ifs, the tracker RTL and aabb_ct_contact_check.
module aabb_contact_tracker_top_tb;
    import aabb_ct_pkg::*;

    localparam int COORD_MIN   = -(1 << (COORD_W - 1));
    localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
    localparam int UNIT        = 256;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 110;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aabb_ct_item_if item_ch ();
    aabb_ct_res_if  res_ch ();
    aabb_ct_cfg_if  cfg_ch ();

    int mismatches;
    int pending_results;
    int enters;
    int stays;
    int exits;
    int items_sent;
    int mask_settings;
    bit hold_results;
    int run_left [2];
    bit steady [2];

    aabb_contact_tracker_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    aabb_ct_contact_check u_contact_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (mismatches),
        .o_pending (pending_results),
        .o_enters  (enters),
        .o_stays   (stays),
        .o_exits   (exits)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_pause(input int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(4, 24);
            steady[side]   = ($urandom_range(0, 2) == 0);
        end
        run_left[side]--;
        return steady[side] ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic int draw_extent();
        int e;
        e = $urandom_range(1, 2048);
        return ($urandom_range(0, 7) == 0) ? -e : e;
    endfunction

    function automatic t_item box_pair(
        input int lid, input int rid, input int ll, input int rl,
        input int lx, input int ly, input int rx, input int ry,
        input int lw, input int lh, input int rw, input int rh
    );
        t_item it;
        it.left_id     = ID_W'(lid);
        it.right_id    = ID_W'(rid);
        it.left_layer  = LAYER_W'(ll);
        it.right_layer = LAYER_W'(rl);
        it.left_x      = COORD_W'(lx);
        it.left_y      = COORD_W'(ly);
        it.right_x     = COORD_W'(rx);
        it.right_y     = COORD_W'(ry);
        it.left_w      = COORD_W'(lw);
        it.left_h      = COORD_W'(lh);
        it.right_w     = COORD_W'(rw);
        it.right_h     = COORD_W'(rh);
        return it;
    endfunction

    function automatic t_item random_pair();
        int kind;
        int lid;
        int rid;
        int lw;
        int lh;
        int rw;
        int rh;
        int span_x;
        int span_y;
        int dx;
        int dy;
        int bx;
        int by;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            return box_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        lw = draw_extent();
        lh = draw_extent();
        rw = draw_extent();
        rh = draw_extent();
        span_x = lw + rw;
        if (span_x < 0) span_x = -span_x;
        span_y = lh + rh;
        if (span_y < 0) span_y = -span_y;
        dx = int'($urandom_range(0, span_x * 3 / 2)) - span_x * 3 / 4;
        dy = int'($urandom_range(0, span_y * 3 / 2)) - span_y * 3 / 4;
        bx = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        by = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        if (kind == 9) begin
            lid = $urandom_range(0, 63);
            rid = $urandom_range(0, 63);
        end else begin
            lid = $urandom_range(0, 7);
            rid = $urandom_range(0, 7);
        end
        return box_pair(lid, rid, $urandom_range(0, 15), $urandom_range(0, 15),
                        bx, by, bx + dx, by + dy, lw, lh, rw, rh);
    endfunction

    task automatic send_pair(input t_item it, input int pause);
        if (pause > 0) begin
            item_ch.valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        wait (pending_results == 0);
        @(negedge i_clk);
    endtask

    task automatic set_layer_masks(input logic [MASK_W-1:0] m [4]);
        for (int i = 0; i <= 4; i++) begin
            cfg_ch.valid <= 1'b1;
            if (i < 4) begin
                cfg_ch.data.idx   <= CFG_LAYER_MASK_0 + CFG_IDX_W'(i);
                cfg_ch.data.wdata <= m[i];
            end else begin
                cfg_ch.data.idx   <= CFG_LAYER_MASK_3 + CFG_IDX_W'($urandom_range(1, 252));
                cfg_ch.data.wdata <= {$urandom, $urandom};
            end
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        mask_settings++;
    endtask

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        @(negedge i_clk);
        forever begin
            int pause;
            if (hold_results) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end
            pause = draw_pause(1);
            if (pause > 0) begin
                res_ch.ready <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [MASK_W-1:0] masks [4];
        i_rst_n       = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        hold_results  = 1'b0;
        items_sent    = 0;
        mask_settings = 1;
        run_left      = '{0, 0};
        steady        = '{0, 0};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_pair(box_pair(1, 2, 0, 0, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), 0);
        wait_idle();
        masks = '{'1, '1, '1, '1};
        set_layer_masks(masks);

        send_pair(box_pair(1, 2, 0, 0, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), 0);
        send_pair(box_pair(1, 2, 3, 9, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), 0);
        send_pair(box_pair(1, 2, 3, 9, 0, 0, 4096, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(1, 2, 3, 9, 0, 0, 4096, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(5, 5, 2, 2, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(3, 4, 1, 1, 0, 0, UNIT, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(3, 4, 1, 1, 0, 0, UNIT - 1, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(3, 4, 1, 1, 0, 0, 10, UNIT, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(6, 7, 4, 5, 0, 0, 100, 100, -UNIT, -UNIT, -UNIT, -UNIT),
                  draw_pause(0));
        send_pair(box_pair(6, 7, 4, 5, 0, 0, 10, 10, 512, 512, -512, 512), draw_pause(0));
        send_pair(box_pair(0, 63, 0, 15, COORD_MIN, 0, COORD_MAX, 0,
                           COORD_MAX, UNIT, COORD_MAX, UNIT), draw_pause(0));
        send_pair(box_pair(63, 0, 15, 0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                           COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), draw_pause(0));
        send_pair(box_pair(0, 63, 0, 15, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                           COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), draw_pause(0));
        send_pair(box_pair(63, 0, 15, 0, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(10, 11, 7, 8, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), 0);
        send_pair(box_pair(10, 11, 7, 8, 0, 0, 9000, 0, UNIT, UNIT, UNIT, UNIT), 0);
        send_pair(box_pair(10, 11, 7, 8, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), 0);
        send_pair(box_pair(11, 10, 7, 8, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), 0);

        wait_idle();
        masks = '{64'h1 << 15, '0, '0, 64'h1 << 48};
        set_layer_masks(masks);
        send_pair(box_pair(20, 21, 0, 15, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(20, 21, 15, 0, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));
        send_pair(box_pair(20, 21, 0, 14, 0, 0, 5000, 0, UNIT, UNIT, UNIT, UNIT),
                  draw_pause(0));
        send_pair(box_pair(20, 21, 15, 0, 0, 0, 5000, 0, UNIT, UNIT, UNIT, UNIT),
                  draw_pause(0));
        send_pair(box_pair(20, 21, 1, 15, 0, 0, 0, 0, UNIT, UNIT, UNIT, UNIT), draw_pause(0));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: masks = '{'1, '1, '1, '1};
                1: masks = '{{$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom}};
                2: masks = '{{$urandom, $urandom} | {$urandom, $urandom},
                             {$urandom, $urandom} | {$urandom, $urandom},
                             {$urandom, $urandom} | {$urandom, $urandom},
                             {$urandom, $urandom} | {$urandom, $urandom}};
                3: masks = '{{$urandom, $urandom} & {$urandom, $urandom},
                             {$urandom, $urandom} & {$urandom, $urandom},
                             {$urandom, $urandom} & {$urandom, $urandom},
                             {$urandom, $urandom} & {$urandom, $urandom}};
                default: masks = '{'0, {$urandom, $urandom}, {$urandom, $urandom}, '1};
            endcase
            set_layer_masks(masks);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == 10) hold_results = 1'b1;
                send_pair(random_pair(), draw_pause(0));
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Drove %0d box pairs under %0d layer mask settings.",
                 items_sent, mask_settings);
        $display("Contact events seen: %0d enter, %0d stay, %0d exit; %0d mismatches.",
                 enters, stays, exits, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
